### hdl/lbbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lbbs_pkg;

   // Field widths
   localparam int OP_BITS      = 2;
   localparam int PRI_BITS     = 2;
   localparam int STATUS_BITS  = 3;
   localparam int PHASE_BITS   = 3;
   localparam int CFG_BITS     = 16;
   localparam int COUNT_BITS   = 16;
   localparam int CSR_IDX_BITS = 3;

   localparam int TIME_BITS_DEF = 16;

   // Opcodes
   localparam logic [OP_BITS-1:0] OP_TICK  = 2'd0;
   localparam logic [OP_BITS-1:0] OP_START = 2'd1;
   localparam logic [OP_BITS-1:0] OP_ONCE  = 2'd2;
   localparam logic [OP_BITS-1:0] OP_HOLD  = 2'd3;

   // Phases
   localparam logic [PHASE_BITS-1:0] PH_OFF   = 3'd0;
   localparam logic [PHASE_BITS-1:0] PH_ON    = 3'd1;
   localparam logic [PHASE_BITS-1:0] PH_SLEEP = 3'd2;
   localparam logic [PHASE_BITS-1:0] PH_ONCE  = 3'd3;
   localparam logic [PHASE_BITS-1:0] PH_KEEP  = 3'd4;

   // Result status codes
   localparam logic [STATUS_BITS-1:0] ST_IDLE    = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_WAIT    = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_TOGGLED = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_ACCEPT  = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_IGNORE  = 3'd4;

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] REG_ON_TIME    = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_OFF_TIME   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_SLEEP_TIME = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_BURST      = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_ONCE_TIME  = 3'd4;

   // Register reset values
   localparam logic [CFG_BITS-1:0] ON_TIME_RST    = 16'd300;
   localparam logic [CFG_BITS-1:0] OFF_TIME_RST   = 16'd200;
   localparam logic [CFG_BITS-1:0] SLEEP_TIME_RST = 16'd2000;
   localparam logic [CFG_BITS-1:0] BURST_RST      = 16'd0;
   localparam logic [CFG_BITS-1:0] ONCE_TIME_RST  = 16'd100;

   localparam logic [PRI_BITS-1:0] PRI_LOW = 2'd1;

   typedef struct packed {
      logic [CFG_BITS-1:0] on_time;
      logic [CFG_BITS-1:0] off_time;
      logic [CFG_BITS-1:0] sleep_time;
      logic [CFG_BITS-1:0] burst_toggles;
      logic [CFG_BITS-1:0] once_time;
   } cfg_type;

   // Channel state, except the elapsed counter whose width is a parameter
   typedef struct packed {
      logic [PHASE_BITS-1:0] phase;
      logic                  light;
      logic [PRI_BITS-1:0]   active;
      logic [COUNT_BITS-1:0] toggle_count;
   } chan_type;

endpackage

`default_nettype wire

### hdl/lbbs_csr.sv
`timescale 1ns / 1ps
`default_nettype none

module lbbs_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [lbbs_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [lbbs_pkg::CFG_BITS-1:0]     csr_wdata,
   output lbbs_pkg::cfg_type                      cfg
);

   lbbs_pkg::cfg_type cfg_ff;
   lbbs_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            lbbs_pkg::REG_ON_TIME:    cfg_in.on_time       = csr_wdata;
            lbbs_pkg::REG_OFF_TIME:   cfg_in.off_time      = csr_wdata;
            lbbs_pkg::REG_SLEEP_TIME: cfg_in.sleep_time    = csr_wdata;
            lbbs_pkg::REG_BURST:      cfg_in.burst_toggles = csr_wdata;
            lbbs_pkg::REG_ONCE_TIME:  cfg_in.once_time     = csr_wdata;
            default:                  cfg_in = cfg_ff;   // drop writes off the map
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.on_time       <= lbbs_pkg::ON_TIME_RST;
         cfg_ff.off_time      <= lbbs_pkg::OFF_TIME_RST;
         cfg_ff.sleep_time    <= lbbs_pkg::SLEEP_TIME_RST;
         cfg_ff.burst_toggles <= lbbs_pkg::BURST_RST;
         cfg_ff.once_time     <= lbbs_pkg::ONCE_TIME_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### hdl/lbbs_step.sv
`timescale 1ns / 1ps
`default_nettype none

module lbbs_step #(
   parameter int TIME_BITS = lbbs_pkg::TIME_BITS_DEF
) (
   input  wire lbbs_pkg::cfg_type                cfg,
   input  wire lbbs_pkg::chan_type               chan,
   input  wire logic [TIME_BITS-1:0]             elapsed,
   input  wire logic [lbbs_pkg::OP_BITS-1:0]     op,
   input  wire logic                             arg,
   input  wire logic [lbbs_pkg::PRI_BITS-1:0]    priority_req,
   output lbbs_pkg::chan_type                    chan_next,
   output logic [TIME_BITS-1:0]                  elapsed_next,
   output logic [lbbs_pkg::STATUS_BITS-1:0]      status
);

   // Compare width covers both the elapsed counter and a 16-bit delay
   localparam int CMP_BITS = (TIME_BITS > lbbs_pkg::CFG_BITS) ? TIME_BITS
                                                              : lbbs_pkg::CFG_BITS;

   logic [lbbs_pkg::CFG_BITS-1:0]   delay;
   logic [TIME_BITS-1:0]            el_inc;
   logic [lbbs_pkg::PRI_BITS-1:0]   pri;
   logic [lbbs_pkg::COUNT_BITS-1:0] tc_inc;
   logic                            burst_done;
   logic                            light_flip;

   always_comb begin
      case (chan.phase)
         lbbs_pkg::PH_ON:    delay = cfg.on_time;
         lbbs_pkg::PH_OFF:   delay = cfg.off_time;
         lbbs_pkg::PH_SLEEP: delay = cfg.sleep_time;
         lbbs_pkg::PH_ONCE:  delay = cfg.once_time;
         default:            delay = '0;
      endcase
   end

   // Saturating increment
   assign el_inc     = (&elapsed) ? elapsed : elapsed + TIME_BITS'(1);
   assign pri        = (priority_req == '0) ? lbbs_pkg::PRI_LOW : priority_req;
   assign tc_inc     = chan.toggle_count + lbbs_pkg::COUNT_BITS'(1);
   assign burst_done = (cfg.burst_toggles != '0) && (tc_inc >= cfg.burst_toggles);
   assign light_flip = ~chan.light;

   always_comb begin
      chan_next    = chan;
      elapsed_next = elapsed;
      status       = lbbs_pkg::ST_IDLE;
      case (op)
         lbbs_pkg::OP_TICK: begin
            if (chan.active == '0 || chan.phase == lbbs_pkg::PH_KEEP) begin
               status = lbbs_pkg::ST_IDLE;
            end else if (CMP_BITS'(el_inc) < CMP_BITS'(delay)) begin
               elapsed_next = el_inc;
               status       = lbbs_pkg::ST_WAIT;
            end else if (chan.phase == lbbs_pkg::PH_ONCE) begin
               // single blink ends: flip back and free the channel
               elapsed_next     = el_inc;
               chan_next.light  = light_flip;
               chan_next.active = '0;
               status           = lbbs_pkg::ST_TOGGLED;
            end else begin
               elapsed_next = '0;
               status       = lbbs_pkg::ST_TOGGLED;
               if (burst_done) begin
                  chan_next.toggle_count = '0;
                  chan_next.phase        = lbbs_pkg::PH_SLEEP;
                  chan_next.light        = 1'b0;
               end else begin
                  chan_next.toggle_count = tc_inc;
                  chan_next.phase        = light_flip ? lbbs_pkg::PH_ON : lbbs_pkg::PH_OFF;
                  chan_next.light        = light_flip;
               end
            end
         end
         lbbs_pkg::OP_START: begin
            if (chan.active > pri) begin
               status = lbbs_pkg::ST_IGNORE;
            end else begin
               chan_next.phase        = lbbs_pkg::PH_OFF;
               chan_next.toggle_count = '0;
               chan_next.active       = pri;
               elapsed_next           = '0;
               status                 = lbbs_pkg::ST_ACCEPT;
            end
         end
         lbbs_pkg::OP_ONCE: begin
            chan_next.phase        = lbbs_pkg::PH_ONCE;
            chan_next.toggle_count = '0;
            chan_next.active       = lbbs_pkg::PRI_LOW;
            chan_next.light        = arg ? light_flip : 1'b1;
            elapsed_next           = '0;
            status                 = lbbs_pkg::ST_ACCEPT;
         end
         default: begin
            chan_next.phase  = lbbs_pkg::PH_KEEP;
            chan_next.active = lbbs_pkg::PRI_LOW;
            chan_next.light  = arg;
            status           = lbbs_pkg::ST_ACCEPT;
         end
      endcase
   end

endmodule

`default_nettype wire

### hdl/led_blink_burst_scheduler_core.sv
`timescale 1ns / 1ps
`default_nettype none
// A word accepted on req_ enters the input register, moves into the result register
// once it is empty or being drained, and shows on rsp_ until taken. With rsp_ready high,
// throughput is one word per cycle; the input register, step logic and result register
// form a two-stage pipe, and the channel state updates as each word leaves stage one.
// Reset: synchronous, active high; clears both stage valids, the channel state
// (off phase, LED dark, no task) and loads the register defaults.

module led_blink_burst_scheduler_core #(
   parameter int TIME_BITS = lbbs_pkg::TIME_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // input words
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [lbbs_pkg::OP_BITS-1:0]      req_op,
   input  wire logic                              req_arg,
   input  wire logic [lbbs_pkg::PRI_BITS-1:0]     req_priority_req,
   // result words
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_light,
   output logic [lbbs_pkg::STATUS_BITS-1:0]       rsp_status,
   // register writes
   input  wire logic                              csr_wr_en,
   input  wire logic [lbbs_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [lbbs_pkg::CFG_BITS-1:0]     csr_wdata
);

   lbbs_pkg::cfg_type  cfg;

   // Stage one: input register
   logic                              in_valid_ff;
   logic [lbbs_pkg::OP_BITS-1:0]      in_op_ff;
   logic                              in_arg_ff;
   logic [lbbs_pkg::PRI_BITS-1:0]     in_pri_ff;

   // Channel state
   lbbs_pkg::chan_type                chan_ff;
   lbbs_pkg::chan_type                chan_in;
   logic [TIME_BITS-1:0]              elapsed_ff;
   logic [TIME_BITS-1:0]              elapsed_in;

   // Stage two: result register
   logic                              rsp_valid_ff;
   logic                              rsp_light_ff;
   logic [lbbs_pkg::STATUS_BITS-1:0]  rsp_status_ff;
   logic [lbbs_pkg::STATUS_BITS-1:0]  status_in;

   logic advance;   // stage one word moves into the result register
   logic req_take;

   lbbs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lbbs_step #(
      .TIME_BITS (TIME_BITS)
   ) u_step (
      .cfg          (cfg),
      .chan         (chan_ff),
      .elapsed      (elapsed_ff),
      .op           (in_op_ff),
      .arg          (in_arg_ff),
      .priority_req (in_pri_ff),
      .chan_next    (chan_in),
      .elapsed_next (elapsed_in),
      .status       (status_in)
   );

   // Advance when stage one holds a word and the result register is empty or being drained
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   // Payload: hold until a new word is taken
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff  <= req_op;
         in_arg_ff <= req_arg;
         in_pri_ff <= req_priority_req;
      end
   end

   // Commit channel state only when the word leaves stage one
   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff.phase        <= lbbs_pkg::PH_OFF;
         chan_ff.light        <= 1'b0;
         chan_ff.active       <= '0;
         chan_ff.toggle_count <= '0;
         elapsed_ff           <= '0;
      end else if (advance) begin
         chan_ff    <= chan_in;
         elapsed_ff <= elapsed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_light_ff  <= chan_in.light;
         rsp_status_ff <= status_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_light  = rsp_light_ff;
   assign rsp_status = rsp_status_ff;

endmodule

`default_nettype wire

### hdl/lbbs_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module lbbs_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_ready,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic                                rsp_light,
   input wire logic [lbbs_pkg::STATUS_BITS-1:0]    rsp_status
);

   // Result word holds while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_light) && $stable(rsp_status))
      else $error("result word changed while stalled");

   // No result word right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // With nothing waiting on the result side the block always takes a word
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled while result side empty");

   // Only defined status codes leave the block
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == lbbs_pkg::ST_IDLE    || rsp_status == lbbs_pkg::ST_WAIT ||
                     rsp_status == lbbs_pkg::ST_TOGGLED || rsp_status == lbbs_pkg::ST_ACCEPT ||
                     rsp_status == lbbs_pkg::ST_IGNORE))
      else $error("undefined status code");

   // A word taken while no result word waits shows up on rsp_ after the input register when not stalled
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid ##1 rsp_ready |=> rsp_valid)
      else $error("result word missing");

endmodule

bind led_blink_burst_scheduler_core lbbs_checker u_lbbs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_light  (rsp_light),
   .rsp_status (rsp_status)
);

`default_nettype wire

### test/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int TIME_BITS    = lbbs_pkg::TIME_BITS_DEF;
   localparam int OP_BITS      = lbbs_pkg::OP_BITS;
   localparam int PRI_BITS     = lbbs_pkg::PRI_BITS;
   localparam int STATUS_BITS  = lbbs_pkg::STATUS_BITS;
   localparam int CFG_BITS     = lbbs_pkg::CFG_BITS;
   localparam int CSR_IDX_BITS = lbbs_pkg::CSR_IDX_BITS;
   // Clock cycles the sink holds rsp_ready low when a test asks for back pressure.
   localparam int HOLD_OFF_CYCLES = 60;
   // Hard stop for the whole run: far above a clean run, stalls and idling included.
   localparam longint RUN_LIMIT_NS = 64'd500_000;

   // One result word as the block reports it.
   typedef struct packed {
      logic                   light;
      logic [STATUS_BITS-1:0] status;
   } led_word_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [OP_BITS-1:0]      req_op;
   logic                    req_arg;
   logic [PRI_BITS-1:0]     req_priority_req;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic                    rsp_light;
   logic [STATUS_BITS-1:0]  rsp_status;
   logic                    csr_wr_en;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [CFG_BITS-1:0]     csr_wdata;

   // Mirror of the channel as the predictor sees it.
   lbbs_pkg::cfg_type       led_cfg;
   lbbs_pkg::chan_type      led_chan;
   logic [TIME_BITS-1:0]    led_elapsed;

   led_word_type            pending_led_words[$];
   int                      mismatch_count;

   // Knobs that the test tasks flip for the two sides.
   bit                      feed_idle_on;
   bit                      drain_idle_on;
   bit                      drain_hold_req;

   led_blink_burst_scheduler_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_arg          (req_arg),
      .req_priority_req (req_priority_req),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_light        (rsp_light),
      .rsp_status       (rsp_status),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Global watchdog: a hung handshake or a lost word ends here.
   initial begin
      #RUN_LIMIT_NS;
      $display("FAILURE");
      $finish;
   end

   // ------------------------------------------------------------------
   // Channel predictor
   // ------------------------------------------------------------------

   task automatic reset_led_model();
      led_cfg.on_time       = lbbs_pkg::ON_TIME_RST;
      led_cfg.off_time      = lbbs_pkg::OFF_TIME_RST;
      led_cfg.sleep_time    = lbbs_pkg::SLEEP_TIME_RST;
      led_cfg.burst_toggles = lbbs_pkg::BURST_RST;
      led_cfg.once_time     = lbbs_pkg::ONCE_TIME_RST;
      led_chan.phase        = lbbs_pkg::PH_OFF;
      led_chan.light        = 1'b0;
      led_chan.active       = '0;
      led_chan.toggle_count = '0;
      led_elapsed           = '0;
   endtask

   // Delay of the phase the channel is sitting in.
   function automatic logic [CFG_BITS-1:0] phase_delay_ticks();
      case (led_chan.phase)
         lbbs_pkg::PH_ON:    return led_cfg.on_time;
         lbbs_pkg::PH_OFF:   return led_cfg.off_time;
         lbbs_pkg::PH_SLEEP: return led_cfg.sleep_time;
         lbbs_pkg::PH_ONCE:  return led_cfg.once_time;
         default:            return '0;
      endcase
   endfunction

   // Advance the channel by one tick and return the tick's status.
   function automatic logic [STATUS_BITS-1:0] advance_tick();
      if (led_chan.active == '0 || led_chan.phase == lbbs_pkg::PH_KEEP)
         return lbbs_pkg::ST_IDLE;
      // Saturate rather than wrap.
      if (led_elapsed != '1)
         led_elapsed = led_elapsed + 1'b1;
      if (led_elapsed < phase_delay_ticks())
         return lbbs_pkg::ST_WAIT;
      led_chan.light = ~led_chan.light;
      if (led_chan.phase == lbbs_pkg::PH_ONCE) begin
         // Single blink is done: free the channel, leave the phase alone.
         led_chan.active = '0;
         return lbbs_pkg::ST_TOGGLED;
      end
      led_chan.phase        = led_chan.light ? lbbs_pkg::PH_ON : lbbs_pkg::PH_OFF;
      led_elapsed           = '0;
      led_chan.toggle_count = led_chan.toggle_count + 1'b1;
      if (led_cfg.burst_toggles != '0 &&
          led_chan.toggle_count >= led_cfg.burst_toggles) begin
         // Burst complete: go dark and sleep.
         led_chan.toggle_count = '0;
         led_chan.phase        = lbbs_pkg::PH_SLEEP;
         led_chan.light        = 1'b0;
      end
      return lbbs_pkg::ST_TOGGLED;
   endfunction

   // Apply one accepted input word and return the word the block owes for it.
   function automatic led_word_type next_led_word(logic [OP_BITS-1:0] op, logic arg,
                                                  logic [PRI_BITS-1:0] pri);
      led_word_type         word;
      logic [PRI_BITS-1:0]  level;
      level = (pri == '0) ? lbbs_pkg::PRI_LOW : pri;
      case (op)
         lbbs_pkg::OP_TICK: word.status = advance_tick();
         lbbs_pkg::OP_START: begin
            if (led_chan.active > level) begin
               word.status = lbbs_pkg::ST_IGNORE;
            end else begin
               // Level is kept; cycling restarts from the off phase.
               led_chan.phase        = lbbs_pkg::PH_OFF;
               led_chan.toggle_count = '0;
               led_elapsed           = '0;
               led_chan.active       = level;
               word.status           = lbbs_pkg::ST_ACCEPT;
            end
         end
         lbbs_pkg::OP_ONCE: begin
            led_chan.phase        = lbbs_pkg::PH_ONCE;
            led_chan.toggle_count = '0;
            led_elapsed           = '0;
            led_chan.active       = lbbs_pkg::PRI_LOW;
            led_chan.light        = arg ? ~led_chan.light : 1'b1;
            word.status           = lbbs_pkg::ST_ACCEPT;
         end
         default: begin
            // Hold: keep the given level, elapsed and count untouched.
            led_chan.phase  = lbbs_pkg::PH_KEEP;
            led_chan.active = lbbs_pkg::PRI_LOW;
            led_chan.light  = arg;
            word.status     = lbbs_pkg::ST_ACCEPT;
         end
      endcase
      word.light = led_chan.light;
      return word;
   endfunction

   // ------------------------------------------------------------------
   // Result side: ready pattern and checking
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t ns: mismatch in %s: got %0d, want %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // Drive rsp_ready. A hold-off request drops ready for the span set by HOLD_OFF_CYCLES
   // so that the pipe fills and the block stalls its input.
   initial begin : drain_ready_proc
      int hold_left;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (drain_hold_req) begin
            hold_left      = HOLD_OFF_CYCLES;
            drain_hold_req = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (drain_idle_on && $urandom_range(99) < 18) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Sample in the middle of the cycle, where every output has settled; a
   // word seen with valid and ready here is taken at the next rising edge.
   initial begin : result_check_proc
      led_word_type want;
      forever begin
         @(negedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (pending_led_words.size() == 0) begin
               report_mismatch("unexpected result word, status", rsp_status, 0);
            end else begin
               want = pending_led_words.pop_front();
               if (rsp_light !== want.light)
                  report_mismatch("light", rsp_light, want.light);
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Input side
   // ------------------------------------------------------------------

   // Offer one word, hold it until taken, and log what the block owes for it.
   // Called right after a rising edge; returns right after the accepting edge.
   task automatic send_led_word(input logic [OP_BITS-1:0] op, input logic arg,
                                input logic [PRI_BITS-1:0] pri);
      while (feed_idle_on && $urandom_range(99) < 18) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_op           <= op;
      req_arg          <= arg;
      req_priority_req <= pri;
      @(negedge clock);
      while (!req_ready) begin
         @(posedge clock);
         @(negedge clock);
      end
      pending_led_words.push_back(next_led_word(op, arg, pri));
      @(posedge clock);
   endtask

   task automatic send_random_word();
      int                 pick;
      logic [OP_BITS-1:0] op;
      pick = $urandom_range(99);
      // Mostly ticks so that the cycling phases actually run their course.
      if (pick < 65)      op = lbbs_pkg::OP_TICK;
      else if (pick < 80) op = lbbs_pkg::OP_START;
      else if (pick < 90) op = lbbs_pkg::OP_ONCE;
      else                op = lbbs_pkg::OP_HOLD;
      send_led_word(op, 1'($urandom_range(1)), PRI_BITS'($urandom_range(3)));
   endtask

   // Drop valid and wait until every owed word has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_led_words.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_BITS-1:0] idx,
                                 input logic [CFG_BITS-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         lbbs_pkg::REG_ON_TIME:    led_cfg.on_time       = data;
         lbbs_pkg::REG_OFF_TIME:   led_cfg.off_time      = data;
         lbbs_pkg::REG_SLEEP_TIME: led_cfg.sleep_time    = data;
         lbbs_pkg::REG_BURST:      led_cfg.burst_toggles = data;
         lbbs_pkg::REG_ONCE_TIME:  led_cfg.once_time     = data;
         default: ;
      endcase
   endtask

   // Load all five registers back to back, then a stray write past the last
   // register, which the block must drop. Only call with the block idle.
   task automatic load_config(input logic [CFG_BITS-1:0] on_ticks,
                              input logic [CFG_BITS-1:0] off_ticks,
                              input logic [CFG_BITS-1:0] sleep_ticks,
                              input logic [CFG_BITS-1:0] burst,
                              input logic [CFG_BITS-1:0] once_ticks);
      write_register(lbbs_pkg::REG_ON_TIME, on_ticks);
      write_register(lbbs_pkg::REG_OFF_TIME, off_ticks);
      write_register(lbbs_pkg::REG_SLEEP_TIME, sleep_ticks);
      write_register(lbbs_pkg::REG_BURST, burst);
      write_register(lbbs_pkg::REG_ONCE_TIME, once_ticks);
      write_register(CSR_IDX_BITS'($urandom_range(lbbs_pkg::REG_ONCE_TIME + 1, 7)),
                     CFG_BITS'($urandom));
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset register values: priority rules, blink once, hold.
   task automatic test_reset_defaults();
      send_led_word(lbbs_pkg::OP_TICK, 1'b1, 2'd3);    // no task yet: idle
      send_led_word(lbbs_pkg::OP_START, 1'b0, 2'd0);   // priority zero counts as one
      send_led_word(lbbs_pkg::OP_TICK, 1'b0, 2'd0);    // waiting out off_time
      send_led_word(lbbs_pkg::OP_START, 1'b1, 2'd3);   // higher priority takes over
      send_led_word(lbbs_pkg::OP_START, 1'b0, 2'd2);   // lower: ignored
      send_led_word(lbbs_pkg::OP_START, 1'b0, 2'd1);   // lower: ignored
      send_led_word(lbbs_pkg::OP_START, 1'b0, 2'd0);   // zero maps to one: ignored
      send_led_word(lbbs_pkg::OP_START, 1'b0, 2'd3);   // equal priority: accepted
      send_led_word(lbbs_pkg::OP_ONCE, 1'b0, 2'd0);    // light up
      send_led_word(lbbs_pkg::OP_TICK, 1'b0, 2'd1);
      send_led_word(lbbs_pkg::OP_ONCE, 1'b1, 2'd2);    // invert current level
      send_led_word(lbbs_pkg::OP_HOLD, 1'b1, 2'd0);
      send_led_word(lbbs_pkg::OP_TICK, 1'b1, 2'd0);    // hold reports idle
      send_led_word(lbbs_pkg::OP_HOLD, 1'b0, 2'd3);
      send_led_word(lbbs_pkg::OP_START, 1'b0, 2'd1);   // hold is priority one: accepted
      drain_results();
   endtask

   // Every delay zero, short burst: each tick toggles, sleep is instant.
   task automatic test_zero_delay();
      load_config(16'd0, 16'd0, 16'd0, 16'd2, 16'd0);
      send_led_word(lbbs_pkg::OP_START, 1'b1, 2'd2);
      repeat (5) send_led_word(lbbs_pkg::OP_TICK, 1'b0, 2'd0);
      send_led_word(lbbs_pkg::OP_ONCE, 1'b0, 2'd1);
      send_led_word(lbbs_pkg::OP_TICK, 1'b1, 2'd2);    // toggles back and frees
      send_led_word(lbbs_pkg::OP_TICK, 1'b0, 2'd3);    // idle now
      send_led_word(lbbs_pkg::OP_START, 1'b0, 2'd1);
      drain_results();
   endtask

   // Random words over several short-delay settings. The first phase runs
   // with no idling on either side.
   task automatic test_random_mix();
      for (int setting = 0; setting < 5; setting++) begin
         feed_idle_on  = (setting != 0);
         drain_idle_on = (setting != 0);
         load_config(CFG_BITS'($urandom_range(6)), CFG_BITS'($urandom_range(6)),
                     CFG_BITS'($urandom_range(8)), CFG_BITS'($urandom_range(4)),
                     CFG_BITS'($urandom_range(6)));
         send_led_word(lbbs_pkg::OP_START, 1'($urandom_range(1)),
                       PRI_BITS'($urandom_range(3)));
         repeat (90) send_random_word();
         drain_results();
      end
      feed_idle_on  = 1'b1;
      drain_idle_on = 1'b1;
   endtask

   // Hold the sink off for a long stretch while words keep coming.
   task automatic test_output_stall();
      load_config(16'd2, 16'd3, 16'd4, 16'd3, 16'd1);
      send_led_word(lbbs_pkg::OP_START, 1'b0, 2'd1);
      drain_hold_req = 1'b1;
      repeat (80) send_random_word();
      drain_results();
   endtask

   // Let the pipe run dry, give stray words a chance to show, then conclude.
   task automatic finish_run();
      int spin;
      req_valid <= 1'b0;
      for (spin = 0; spin < 5000 && pending_led_words.size() != 0; spin++)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (pending_led_words.size() != 0)
         report_mismatch("words never returned, count", 0, pending_led_words.size());
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_op           = lbbs_pkg::OP_TICK;
      req_arg          = 1'b0;
      req_priority_req = '0;
      csr_wr_en        = 1'b0;
      csr_index        = lbbs_pkg::REG_ON_TIME;
      csr_wdata        = '0;
      mismatch_count   = 0;
      feed_idle_on     = 1'b1;
      drain_idle_on    = 1'b1;
      drain_hold_req   = 1'b0;
      reset_led_model();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_zero_delay();
      test_random_mix();
      test_output_stall();
      finish_run();
   end

endmodule
